>>> design/xtn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtn_pkg
// Shared constants, types and helper functions of the text run normalizer.
// ----------------------------------------------------------------------------
package xtn_pkg;

	localparam int ENTITY_WINDOW = 16;
	localparam int EW_BITS       = $clog2(ENTITY_WINDOW);
	localparam int CNT_BITS      = $clog2(ENTITY_WINDOW + 1);
	localparam logic [16:0] POOL_BYTES = 17'd65536;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] CP_SAT     = 21'h110000;
	localparam int NUM_NAMES = 5;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_XL    = 8'h78;
	localparam logic [7:0] CH_XU    = 8'h58;

	typedef struct packed {
		logic [7:0]  data;
		logic        written;
		logic [15:0] addr;
		logic        done;
		logic [16:0] offset;
		logic [16:0] length;
		logic        ovf;
	} res_t;

	typedef struct packed {
		logic                push;
		logic [7:0]          push_data;
		logic                drop;
		logic [CNT_BITS-1:0] drop_n;
		logic                clear;
	} buf_op_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
			(c == 8'h0C) || (c == 8'h0B);
	endfunction

	function automatic logic [2:0] name_len(input int e);
		case (e)
			0:       return 3'd3;
			1, 2:    return 3'd2;
			default: return 3'd4;
		endcase
	endfunction

	// letters of amp, lt, gt, quot, apos
	function automatic logic [7:0] name_chr(input int e, input logic [2:0] k);
		logic [31:0] s;
		case (e)
			0:       s = {8'h61, 8'h6D, 8'h70, 8'h00};
			1:       s = {8'h6C, 8'h74, 8'h00, 8'h00};
			2:       s = {8'h67, 8'h74, 8'h00, 8'h00};
			3:       s = {8'h71, 8'h75, 8'h6F, 8'h74};
			default: s = {8'h61, 8'h70, 8'h6F, 8'h73};
		endcase
		case (k)
			3'd0:    return s[31:24];
			3'd1:    return s[23:16];
			3'd2:    return s[15:8];
			3'd3:    return s[7:0];
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] name_code(input int e);
		case (e)
			0:       return 8'h26;
			1:       return 8'h3C;
			2:       return 8'h3E;
			3:       return 8'h22;
			default: return 8'h27;
		endcase
	endfunction

	// {valid, value}
	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
		if (hex && c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
		if (hex && c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
		return 5'd0;
	endfunction

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		if (cp < 21'h80) return 3'd1;
		if (cp < 21'h800) return 3'd2;
		if (cp < 21'h10000) return 3'd3;
		return 3'd4;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] j);
		logic [2:0] n;
		n = utf8_len(cp);
		if (j == 2'd0) begin
			case (n)
				3'd1:    return cp[7:0];
				3'd2:    return {3'b110, cp[10:6]};
				3'd3:    return {4'b1110, cp[15:12]};
				default: return {5'b11110, cp[20:18]};
			endcase
		end
		// continuation byte j carries bits 6*(n-1-j) upward
		case (3'(n - 3'd1 - {1'b0, j}))
			3'd0:    return {2'b10, cp[5:0]};
			3'd1:    return {2'b10, cp[11:6]};
			default: return {2'b10, cp[17:12]};
		endcase
	endfunction

endpackage

>>> design/xtn_ebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtn_ebuf
// Circular entity lookahead buffer: append at the tail, drop from the head,
// one read port addressed relative to the head.
// ----------------------------------------------------------------------------
module xtn_ebuf
	import xtn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  buf_op_t             op,
	input  logic [EW_BITS-1:0]  rd_idx,
	output logic [7:0]          rd_data,
	output logic [CNT_BITS-1:0] count
);

	logic [7:0]          mem_q [ENTITY_WINDOW];
	logic [EW_BITS-1:0]  head_q;
	logic [CNT_BITS-1:0] count_q;
	logic                can_push;

	assign can_push = op.push && (count_q < CNT_BITS'(ENTITY_WINDOW));
	assign rd_data  = mem_q[EW_BITS'(head_q + rd_idx)];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (op.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (can_push) begin
			count_q <= CNT_BITS'(count_q + 1'b1);
		end else if (op.drop) begin
			head_q  <= EW_BITS'(head_q + op.drop_n[EW_BITS-1:0]);
			count_q <= CNT_BITS'(count_q - op.drop_n);
		end
	end

	always_ff @(posedge clk) begin
		if (!op.clear && can_push)
			mem_q[EW_BITS'(head_q + count_q[EW_BITS-1:0])] <= op.push_data;
	end

endmodule

>>> design/xml_text_run_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_text_run_normalizer
// Entity decode and whitespace collapse of text run bytes into a text pool.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  cfg       psel penable pwrite paddr ...    apb slave, pool_limit at 0x0
//  in        in_valid/in_ready + 3 fields     one source byte per transfer
//  out       out_valid/out_ready + 8 fields   one pool write or status
//
//  each byte added to a pending entity rescans the buffer, one character per cycle
//  every result holds the sequencer while out is stalled
//  one result is held back so the final one of an item carries last_result
//  in_ready is high only while the sequencer is idle; reset is arst_n
// ----------------------------------------------------------------------------
module xml_text_run_normalizer
	import xtn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        byte_valid,
	input  logic        last_in_run,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_written,
	output logic [15:0] pool_address,
	output logic        run_done,
	output logic [16:0] run_offset,
	output logic [16:0] run_length,
	output logic        overflow,
	output logic        last_result
);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_FEED, S_CPNEXT, S_POST, S_SETTLE, S_J1, S_JHASH,
		S_JNUM, S_JNAME, S_RESOLVE, S_DROP1, S_REPLAY, S_OVF, S_STATUS, S_FINISH
	} state_t;

	typedef enum logic [1:0] {J_PEND, J_OK, J_FAIL} judge_t;

	state_t              state_q, ret_q;
	judge_t              jr_q;
	logic [7:0]          in_b_q;
	logic                in_valid_q, in_last_q, closing_q;
	logic [16:0]         pool_limit_q, pool_used_q, run_start_q;
	logic                prior_q, run_failed_q;
	logic                hex_q, digits_q;
	logic [CNT_BITS-1:0] idx_q, used_q;
	logic [NUM_NAMES-1:0] alive_q;
	logic [20:0]         cp_q;
	logic [1:0]          j_q;
	logic [7:0]          feed_c_q;
	res_t                hold_q, out_q;
	logic                hold_v_q, out_valid_q, out_last_q;

	buf_op_t             bop;
	logic [EW_BITS-1:0]  rd_idx;
	logic [7:0]          rd_c;
	logic [CNT_BITS-1:0] cnt;

	logic [16:0]         lim;
	logic                out_free, feed_ws, room;
	logic                push_req, push_ok;
	res_t                push_res;
	logic [4:0]          dig;
	logic [25:0]         cp_mult, cp_next;
	logic [NUM_NAMES-1:0] keep;
	logic                name_hit;
	logic [7:0]          name_cp;
	logic [CNT_BITS-1:0] name_used;
	judge_t              jr_eff;

	xtn_ebuf u_ebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (bop),
		.rd_idx  (rd_idx),
		.rd_data (rd_c),
		.count   (cnt)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {15'd0, pool_limit_q} : 32'd0;

	assign lim      = (pool_limit_q < POOL_BYTES) ? pool_limit_q : POOL_BYTES;
	assign out_free = !out_valid_q || out_ready;
	assign feed_ws  = is_ws(feed_c_q);
	assign room     = pool_used_q < lim;
	assign in_ready = (state_q == S_IDLE);

	assign out_valid    = out_valid_q;
	assign out_byte     = out_q.data;
	assign byte_written = out_q.written;
	assign pool_address = out_q.addr;
	assign run_done     = out_q.done;
	assign run_offset   = out_q.offset;
	assign run_length   = out_q.length;
	assign overflow     = out_q.ovf;
	assign last_result  = out_last_q;

	always_comb begin
		case (state_q)
			S_J1:    rd_idx = EW_BITS'(1);
			S_JHASH: rd_idx = EW_BITS'(2);
			S_JNUM,
			S_JNAME: rd_idx = idx_q[EW_BITS-1:0];
			default: rd_idx = '0;
		endcase
	end

	// numeric accumulate, saturating above the code point range
	always_comb begin
		dig     = digit_of(rd_c, hex_q);
		cp_mult = hex_q ? {1'b0, cp_q, 4'd0} : (26'(cp_q) << 3) + (26'(cp_q) << 1);
		cp_next = cp_mult + 26'(dig[3:0]);
	end

	// named references checked in parallel, one character per cycle
	always_comb begin
		name_hit  = 1'b0;
		name_cp   = 8'd0;
		name_used = '0;
		keep      = '0;
		for (int e = 0; e < NUM_NAMES; e++) begin
			if (alive_q[e] && idx_q == CNT_BITS'(name_len(e) + 3'd1) && rd_c == CH_SEMI) begin
				name_hit  = 1'b1;
				name_cp   = name_code(e);
				name_used = CNT_BITS'(name_len(e) + 3'd2);
			end
			keep[e] = alive_q[e] && (idx_q <= CNT_BITS'(name_len(e))) &&
				(rd_c == name_chr(e, 3'(idx_q - 1'b1)));
		end
	end

	always_comb begin
		jr_eff = jr_q;
		if (jr_q == J_PEND && (closing_q || cnt >= CNT_BITS'(ENTITY_WINDOW)))
			jr_eff = J_FAIL;
	end

	always_comb begin
		push_req = 1'b0;
		push_res = '0;
		push_res.offset = run_start_q;
		case (state_q)
			S_FEED: begin
				if (!(feed_ws && prior_q) && room) begin
					push_req         = 1'b1;
					push_res.data    = feed_ws ? CH_SPACE : feed_c_q;
					push_res.written = 1'b1;
					push_res.addr    = pool_used_q[15:0];
				end
			end
			S_OVF: begin
				push_req     = 1'b1;
				push_res.ovf = 1'b1;
			end
			S_STATUS: begin
				push_req        = 1'b1;
				push_res.done   = 1'b1;
				push_res.length = 17'(pool_used_q - run_start_q);
			end
			default: ;
		endcase
		push_ok = push_req && (!hold_v_q || out_free);
	end

	always_comb begin
		bop = '0;
		case (state_q)
			S_START: begin
				if (!run_failed_q && in_valid_q && !(cnt == '0 && in_b_q != CH_AMP)) begin
					bop.push      = 1'b1;
					bop.push_data = in_b_q;
				end
				if (run_failed_q && in_last_q)
					bop.clear = 1'b1;
			end
			S_CPNEXT: begin
				if (3'({1'b0, j_q} + 3'd1) == utf8_len(cp_q)) begin
					bop.drop   = 1'b1;
					bop.drop_n = used_q;
				end
			end
			S_DROP1: begin
				bop.drop   = 1'b1;
				bop.drop_n = CNT_BITS'(1);
			end
			S_OVF:    bop.clear = push_ok;
			S_STATUS: bop.clear = push_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_limit_q <= POOL_BYTES;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			pool_limit_q <= pwdata[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			jr_q         <= J_PEND;
			pool_used_q  <= '0;
			run_start_q  <= '0;
			prior_q      <= 1'b1;
			run_failed_q <= 1'b0;
			hold_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
			closing_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (push_ok) begin
				if (hold_v_q) begin
					out_q       <= hold_q;
					out_valid_q <= 1'b1;
					out_last_q  <= 1'b0;
				end
				hold_q   <= push_res;
				hold_v_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_b_q     <= in_byte;
						in_valid_q <= byte_valid;
						in_last_q  <= last_in_run;
						closing_q  <= 1'b0;
						state_q    <= S_START;
					end
				end
				S_START: begin
					if (run_failed_q) begin
						if (in_last_q) begin
							run_start_q  <= pool_used_q;
							prior_q      <= 1'b1;
							run_failed_q <= 1'b0;
						end
						state_q <= S_FINISH;
					end else if (!in_valid_q) begin
						state_q <= S_POST;
					end else if (cnt == '0 && in_b_q != CH_AMP) begin
						feed_c_q <= in_b_q;
						ret_q    <= S_POST;
						state_q  <= S_FEED;
					end else begin
						state_q <= S_SETTLE;
					end
				end
				S_FEED: begin
					if (feed_ws && prior_q) begin
						state_q <= ret_q;
					end else if (!room) begin
						prior_q <= feed_ws;
						state_q <= S_OVF;
					end else if (push_ok) begin
						prior_q     <= feed_ws;
						pool_used_q <= 17'(pool_used_q + 1'b1);
						state_q     <= ret_q;
					end
				end
				S_CPNEXT: begin
					if (3'({1'b0, j_q} + 3'd1) == utf8_len(cp_q)) begin
						state_q <= S_REPLAY;
					end else begin
						j_q      <= 2'(j_q + 1'b1);
						feed_c_q <= utf8_byte(cp_q, 2'(j_q + 1'b1));
						ret_q    <= S_CPNEXT;
						state_q  <= S_FEED;
					end
				end
				S_POST: begin
					if (in_last_q) begin
						closing_q <= 1'b1;
						state_q   <= S_SETTLE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_SETTLE: begin
					if (cnt == '0) begin
						state_q <= closing_q ? S_STATUS : S_POST;
					end else if (cnt < CNT_BITS'(2)) begin
						jr_q    <= J_PEND;
						state_q <= S_RESOLVE;
					end else begin
						state_q <= S_J1;
					end
				end
				S_J1: begin
					cp_q     <= '0;
					digits_q <= 1'b0;
					hex_q    <= 1'b0;
					if (rd_c == CH_HASH) begin
						state_q <= S_JHASH;
					end else begin
						alive_q <= '1;
						idx_q   <= CNT_BITS'(1);
						state_q <= S_JNAME;
					end
				end
				S_JHASH: begin
					if (cnt > CNT_BITS'(2) && (rd_c == CH_XL || rd_c == CH_XU)) begin
						hex_q <= 1'b1;
						idx_q <= CNT_BITS'(3);
					end else begin
						idx_q <= CNT_BITS'(2);
					end
					state_q <= S_JNUM;
				end
				S_JNUM: begin
					if (idx_q >= cnt) begin
						jr_q    <= J_PEND;
						state_q <= S_RESOLVE;
					end else if (rd_c == CH_SEMI) begin
						jr_q    <= digits_q ? J_OK : J_FAIL;
						used_q  <= CNT_BITS'(idx_q + 1'b1);
						state_q <= S_RESOLVE;
					end else if (!dig[4]) begin
						jr_q    <= J_FAIL;
						state_q <= S_RESOLVE;
					end else begin
						cp_q     <= (cp_next > 26'(CP_MAX)) ? CP_SAT : cp_next[20:0];
						digits_q <= 1'b1;
						idx_q    <= CNT_BITS'(idx_q + 1'b1);
					end
				end
				S_JNAME: begin
					if (idx_q >= cnt || idx_q > CNT_BITS'(5)) begin
						jr_q    <= (alive_q != '0) ? J_PEND : J_FAIL;
						state_q <= S_RESOLVE;
					end else if (name_hit) begin
						jr_q    <= J_OK;
						cp_q    <= 21'(name_cp);
						used_q  <= name_used;
						state_q <= S_RESOLVE;
					end else begin
						alive_q <= keep;
						idx_q   <= CNT_BITS'(idx_q + 1'b1);
					end
				end
				S_RESOLVE: begin
					unique case (jr_eff)
						J_PEND: state_q <= closing_q ? S_STATUS : S_POST;
						J_OK: begin
							if (cp_q > CP_MAX) begin
								cp_q     <= CP_MAX;
								feed_c_q <= utf8_byte(CP_MAX, 2'd0);
							end else begin
								feed_c_q <= utf8_byte(cp_q, 2'd0);
							end
							j_q     <= 2'd0;
							ret_q   <= S_CPNEXT;
							state_q <= S_FEED;
						end
						default: begin
							feed_c_q <= CH_AMP;
							ret_q    <= S_DROP1;
							state_q  <= S_FEED;
						end
					endcase
				end
				S_DROP1: state_q <= S_REPLAY;
				S_REPLAY: begin
					// literal bytes ahead of the next '&' go out as they are
					if (cnt != '0 && rd_c != CH_AMP) begin
						feed_c_q <= rd_c;
						ret_q    <= S_DROP1;
						state_q  <= S_FEED;
					end else begin
						state_q <= S_SETTLE;
					end
				end
				S_OVF: begin
					if (push_ok) begin
						if (in_last_q) begin
							run_start_q <= pool_used_q;
							prior_q     <= 1'b1;
						end else begin
							run_failed_q <= 1'b1;
						end
						state_q <= S_FINISH;
					end
				end
				S_STATUS: begin
					if (push_ok) begin
						run_start_q <= pool_used_q;
						prior_q     <= 1'b1;
						state_q     <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q       <= hold_q;
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						hold_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// entity buffer never holds more than the window
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CNT_BITS'(ENTITY_WINDOW))
		else $error("entity buffer count beyond window");

	// the held result is always flushed before a new item is taken
	a_hold_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !hold_v_q)
		else $error("held result pending while taking input");

	// a run status or overflow report closes the results of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (run_done || overflow)) |-> last_result)
		else $error("status transfer not marked last");

endmodule

>>> bench/tb_xml_text_run_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_text_run_normalizer
// Drives byte items into the text run normalizer and checks every pool write
// and status result against a cycle-free predictor of entity decode,
// whitespace collapse, pool limit and run bookkeeping.
// ----------------------------------------------------------------------------
module tb_xml_text_run_normalizer;
	import xtn_pkg::*;

	typedef struct {
		logic [7:0]  data;
		logic        written;
		logic [15:0] addr;
		logic        done;
		logic [16:0] offset;
		logic [16:0] length;
		logic        ovf;
		logic        last;
	} pool_result_t;

	typedef enum int {ENT_PENDING, ENT_DECODED, ENT_BROKEN} ent_verdict_t;

	localparam logic [2:0] REG_POOL_LIMIT = 3'd0;
	localparam int DRAIN_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [7:0]  in_byte;
	logic        byte_valid, last_in_run;
	logic        out_valid, out_ready;
	logic [7:0]  out_byte;
	logic        byte_written;
	logic [15:0] pool_address;
	logic        run_done;
	logic [16:0] run_offset, run_length;
	logic        overflow, last_result;

	xml_text_run_normalizer u_top (.*);

	// predictor state
	int unsigned  limit_reg;
	int unsigned  pool_fill;
	bit           after_space;
	logic [7:0]   ent_buf[ENTITY_WINDOW];
	int           ent_len;
	int unsigned  run_base;
	bit           run_dead;
	pool_result_t pending_results[$];

	int errors, items_sent, results_seen, overflows_seen, runs_closed;
	int gap_pct, stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	// ---------------- predictor ----------------
	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
			c == 8'h0C || c == 8'h0B;
	endfunction

	function automatic void push_result(logic [7:0] d, bit wr, int unsigned a, bit dn,
		int unsigned len, bit ov);
		pool_result_t r;
		r.data = d; r.written = wr; r.addr = a[15:0]; r.done = dn;
		r.offset = run_base[16:0]; r.length = len[16:0]; r.ovf = ov; r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	function automatic bit store_byte(logic [7:0] c);
		int unsigned lim;
		lim = limit_reg < 65536 ? limit_reg : 65536;
		if (is_blank(c)) begin
			if (after_space) return 1'b1;
			c = CH_SPACE;
			after_space = 1'b1;
		end else begin
			after_space = 1'b0;
		end
		if (pool_fill >= lim) return 1'b0;
		push_result(c, 1'b1, pool_fill, 1'b0, 0, 1'b0);
		pool_fill++;
		return 1'b1;
	endfunction

	function automatic bit store_codepoint(int unsigned cp);
		logic [7:0] seq[4];
		int n;
		if (cp > 32'h10FFFF) cp = 32'h10FFFF;
		if (cp < 32'h80) begin
			seq[0] = cp[7:0]; n = 1;
		end else if (cp < 32'h800) begin
			seq[0] = {3'b110, cp[10:6]}; seq[1] = {2'b10, cp[5:0]}; n = 2;
		end else if (cp < 32'h10000) begin
			seq[0] = {4'b1110, cp[15:12]}; seq[1] = {2'b10, cp[11:6]};
			seq[2] = {2'b10, cp[5:0]}; n = 3;
		end else begin
			seq[0] = {5'b11110, cp[20:18]}; seq[1] = {2'b10, cp[17:12]};
			seq[2] = {2'b10, cp[11:6]}; seq[3] = {2'b10, cp[5:0]}; n = 4;
		end
		for (int k = 0; k < n; k++)
			if (!store_byte(seq[k])) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int digit_val(logic [7:0] c, bit hex);
		if (c >= "0" && c <= "9") return c - "0";
		if (hex && c >= "a" && c <= "f") return c - "a" + 10;
		if (hex && c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic ent_verdict_t judge_entity(output int unsigned cp,
		output int consumed);
		string names[5];
		logic [7:0] codes[5];
		int i, d, digits;
		bit hex, waiting, hit;
		int unsigned acc, base;
		names = '{"amp", "lt", "gt", "quot", "apos"};
		codes = '{CH_AMP, 8'h3C, 8'h3E, 8'h22, 8'h27};
		cp = 0; consumed = 1; waiting = 1'b0;
		if (ent_len < 2) return ENT_PENDING;
		if (ent_buf[1] == CH_HASH) begin
			hex = 1'b0; i = 2; acc = 0; digits = 0;
			if (ent_len > 2 && (ent_buf[2] == CH_XL || ent_buf[2] == CH_XU)) begin
				hex = 1'b1; i = 3;
			end
			base = hex ? 16 : 10;
			while (i < ent_len && ent_buf[i] != CH_SEMI) begin
				d = digit_val(ent_buf[i], hex);
				if (d < 0) return ENT_BROKEN;
				acc = acc * base + d;
				if (acc > 32'h10FFFF) acc = 32'h110000;
				digits++;
				i++;
			end
			if (i >= ent_len) return ENT_PENDING;
			if (digits == 0) return ENT_BROKEN;
			cp = acc; consumed = i + 1;
			return ENT_DECODED;
		end
		for (int e = 0; e < 5; e++) begin
			hit = 1'b1;
			for (int k = 0; k < names[e].len() && 1 + k < ent_len; k++)
				if (ent_buf[1 + k] != names[e][k]) begin
					hit = 1'b0;
					break;
				end
			if (!hit) continue;
			if (ent_len <= 1 + names[e].len()) begin
				waiting = 1'b1;
				continue;
			end
			if (ent_buf[1 + names[e].len()] == CH_SEMI) begin
				cp = codes[e]; consumed = names[e].len() + 2;
				return ENT_DECODED;
			end
		end
		return waiting ? ENT_PENDING : ENT_BROKEN;
	endfunction

	function automatic void drop_entity_front(int k);
		if (k > ent_len) k = ent_len;
		for (int i = 0; i + k < ent_len; i++) ent_buf[i] = ent_buf[i + k];
		ent_len -= k;
	endfunction

	function automatic bit resolve_entities(bit closing);
		ent_verdict_t v;
		int unsigned cp;
		int consumed;
		while (ent_len > 0) begin
			v = judge_entity(cp, consumed);
			if (v == ENT_PENDING && (closing || ent_len >= ENTITY_WINDOW)) v = ENT_BROKEN;
			if (v == ENT_PENDING) break;
			if (v == ENT_DECODED) begin
				if (!store_codepoint(cp)) return 1'b0;
				drop_entity_front(consumed);
			end else begin
				if (!store_byte(CH_AMP)) return 1'b0;
				drop_entity_front(1);
			end
			while (ent_len > 0 && ent_buf[0] != CH_AMP) begin
				if (!store_byte(ent_buf[0])) return 1'b0;
				drop_entity_front(1);
			end
		end
		return 1'b1;
	endfunction

	function automatic void start_run();
		run_base = pool_fill;
		after_space = 1'b1;
		ent_len = 0;
		run_dead = 1'b0;
	endfunction

	function automatic void predict_normalized(logic [7:0] b, bit bv, bit lst);
		int first;
		bit ok;
		first = pending_results.size();
		ok = 1'b1;
		if (run_dead) begin
			if (lst) start_run();
			return;
		end
		if (bv) begin
			if (ent_len == 0 && b != CH_AMP) begin
				ok = store_byte(b);
			end else begin
				if (ent_len < ENTITY_WINDOW) begin
					ent_buf[ent_len] = b;
					ent_len++;
				end
				ok = resolve_entities(1'b0);
			end
		end
		if (ok && lst) ok = resolve_entities(1'b1);
		if (!ok) begin
			push_result(8'h00, 1'b0, 0, 1'b0, 0, 1'b1);
			ent_len = 0;
			if (lst) start_run();
			else run_dead = 1'b1;
		end else if (lst) begin
			push_result(8'h00, 1'b0, 0, 1'b1, pool_fill - run_base, 1'b0);
			start_run();
		end
		if (pending_results.size() > first)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	// ---------------- result check ----------------
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			pool_result_t e;
			results_seen++;
			if (overflow) overflows_seen++;
			if (run_done) runs_closed++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result byte=%h written=%b", out_byte,
					byte_written);
			end else begin
				e = pending_results.pop_front();
				if (out_byte !== e.data || byte_written !== e.written ||
					pool_address !== e.addr || run_done !== e.done ||
					run_offset !== e.offset || run_length !== e.length ||
					overflow !== e.ovf || last_result !== e.last) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch exp byte=%h wr=%b addr=%0d done=%b off=%0d len=%0d ",
							"ovf=%b last=%b / got %h %b %0d %b %0d %0d %b %b"},
							e.data, e.written, e.addr, e.done, e.offset, e.length, e.ovf,
							e.last, out_byte, byte_written, pool_address, run_done,
							run_offset, run_length, overflow, last_result);
				end
			end
		end
	end

	// ---------------- drivers ----------------
	task automatic send_item(logic [7:0] b, bit bv, bit lst);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_normalized(b, bv, lst);
		in_valid <= 1'b1;
		in_byte <= b;
		byte_valid <= bv;
		last_in_run <= lst;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(string s, bit close);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, close && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pool_limit(int unsigned v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= REG_POOL_LIMIT; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		limit_reg = v & 32'h1FFFF;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic string random_piece();
		case ($urandom_range(11))
			0, 1: return $sformatf("%c%c%c", $urandom_range(33, 126),
				$urandom_range(33, 126), $urandom_range(128, 255));
			2: return {" ", "\t", "\n"};
			3: return "&amp;";
			4: begin
				string nm[5];
				nm = '{"&lt;", "&gt;", "&quot;", "&apos;", "&amp;"};
				return nm[$urandom_range(4)];
			end
			5: return $sformatf("&#%0d;", $urandom_range(2000000));
			6: return $sformatf($urandom_range(1) ? "&#x%h;" : "&#X%H;",
				$urandom_range(24'hFFFFFF));
			7: begin
				string bad[8];
				bad = '{"&am", "&#;", "&#x;", "&xyz;", "&#12a;", "&LT;", "&&lt;", "&ampx"};
				return bad[$urandom_range(7)];
			end
			8: return "&#000000000000065;";
			9: return $sformatf("%c%c", $urandom_range(255), $urandom_range(255));
			10: return "&qu";
			default: return $sformatf("%c", $urandom_range(8, 14));
		endcase
	endfunction

	task automatic send_random_run();
		string s;
		int n;
		s = "";
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) s = {s, random_piece()};
		case ($urandom_range(9))
			0: begin
				send_text(s, 1'b0);
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			end
			1, 2: begin
				send_text(s, 1'b0);
				send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			end
			default: send_text(s, 1'b1);
		endcase
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		gap_pct = 0; stall_pct = 0;
		send_item(8'h0B, 1'b1, 1'b0);
		send_text(" \tA", 1'b0);
		send_item(8'h0C, 1'b1, 1'b0);
		send_text(" &gt;", 1'b1);
		send_text("&#99999999;", 1'b1);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_text("&ap", 1'b1);
		wait_drained();
	endtask

	task automatic test_random(int target, int gp, int sp);
		gap_pct = gp; stall_pct = sp;
		while (items_sent < target) send_random_run();
		wait_drained();
	endtask

	task automatic test_overflow();
		write_pool_limit(pool_fill + 9);
		gap_pct = 20; stall_pct = 20;
		send_random_run();
		send_text("abcdefghijklmnop", 1'b1);
		wait_drained();
		write_pool_limit(0);
		send_text("xy&lt;", 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; in_byte = '0; byte_valid = 1'b0; last_in_run = 1'b0;
		out_ready = 1'b0;
		gap_pct = 0; stall_pct = 0;
		errors = 0; items_sent = 0; results_seen = 0; overflows_seen = 0; runs_closed = 0;
		limit_reg = 65536; pool_fill = 0; ent_len = 0; run_base = 0;
		after_space = 1'b1; run_dead = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(items_sent + 15, 0, 0);
		write_pool_limit(17'h1FFFF);
		test_random(items_sent + 15, 85, 0);
		test_random(items_sent + 15, 0, 85);
		test_overflow();
		write_pool_limit(65536);
		test_random(items_sent + 20, 8, 8);

		$display("covered %0d items, %0d results, %0d closed runs, %0d overflow reports",
			items_sent, results_seen, runs_closed, overflows_seen);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
